// ----- design/set_assoc_lru_cache_sim_macros.svh -----
// Assertion macros shared by the checker
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
// Implication checked on every clock edge outside reset
`define SALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/salc_pkg.sv -----
// -----------------------------------------------------------------------------
// salc_pkg
// Types and constants for the set-associative LRU cache simulator.
// -----------------------------------------------------------------------------
package salc_pkg;
	localparam int unsigned CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_FETCH  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_STORE  = 2'd2,
		OP_MODIFY = 2'd3
	} op_t;

	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_OFF_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS     = 2'd2;

	// Outcome of one lookup
	typedef struct packed {
		logic hit;
		logic miss;
		logic evict;
	} outcome_t;
endpackage

// ----- design/salc_stream_if.sv -----
// -----------------------------------------------------------------------------
// salc_req_if / salc_rsp_if
// Valid/ready channels for access words and result words.
// -----------------------------------------------------------------------------
interface salc_req_if #(parameter int ADDRESS_BITS = 64);
	logic                    valid;
	logic                    ready;
	logic [1:0]              operation;
	logic [ADDRESS_BITS-1:0] address;
	modport source (output valid, operation, address, input ready);
	modport sink (input valid, operation, address, output ready);
endinterface

interface salc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        miss;
	logic        evict;
	logic        second_hit;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] evict_total;
	modport source (output valid, hit, miss, evict, second_hit, hit_total, miss_total,
		evict_total, input ready);
	modport sink (input valid, hit, miss, evict, second_hit, hit_total, miss_total,
		evict_total, output ready);
endinterface

// ----- design/salc_set_mem.sv -----
// -----------------------------------------------------------------------------
// salc_set_mem
// One row per set: valid, tag and rank of every way. Registered read.
// -----------------------------------------------------------------------------
module salc_set_mem #(
	parameter int SETS = 256,
	parameter int ROW_W = 8
) (
	input  logic                    clk,
	input  logic [$clog2(SETS)-1:0] raddr,
	output logic [ROW_W-1:0]        rdata,
	input  logic                    we,
	input  logic [$clog2(SETS)-1:0] waddr,
	input  logic [ROW_W-1:0]        wdata
);
	logic [ROW_W-1:0] mem [SETS];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- design/salc_lookup.sv -----
// -----------------------------------------------------------------------------
// salc_lookup
// Tag compare, fill or victim choice, and LRU rank update for one set row.
// -----------------------------------------------------------------------------
module salc_lookup
	import salc_pkg::*;
#(
	parameter int WAYS = 8,
	parameter int TAG_W = 62,
	parameter int RANK_W = 3
) (
	input  logic [WAYS-1:0]             valid_in,
	input  logic [WAYS-1:0][TAG_W-1:0]  tag_in,
	input  logic [WAYS-1:0][RANK_W-1:0] rank_in,
	input  logic [WAYS-1:0]             use_mask,
	input  logic [TAG_W-1:0]            tag,
	output logic [WAYS-1:0]             valid_out,
	output logic [WAYS-1:0][TAG_W-1:0]  tag_out,
	output logic [WAYS-1:0][RANK_W-1:0] rank_out,
	output outcome_t                    outcome
);
	localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [RANK_W:0] RANK_TOP = (RANK_W + 1)'(WAYS - 1);
	localparam logic [RANK_W:0] RANK_FILL = (RANK_W + 1)'(WAYS);

	logic [WAYS-1:0] match;
	logic [WAYS-1:0] empty;
	logic            any_hit;
	logic            any_empty;
	logic [WI_W-1:0] hit_w;
	logic [WI_W-1:0] empty_w;
	logic [WI_W-1:0] vic_w;
	logic [WI_W-1:0] sel_w;
	logic [RANK_W:0] old_rank;

	// Find hit way, first empty way and oldest way
	always_comb begin
		any_hit = 1'b0;
		any_empty = 1'b0;
		hit_w = '0;
		empty_w = '0;
		vic_w = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			match[j] = use_mask[j] && valid_in[j] && (tag_in[j] == tag);
			empty[j] = use_mask[j] && !valid_in[j];
			if (match[j]) begin
				any_hit = 1'b1;
				hit_w = WI_W'(j);
			end
			if (empty[j]) begin
				any_empty = 1'b1;
				empty_w = WI_W'(j);
			end
		end
		for (int j = 1; j < WAYS; j++) begin
			if (use_mask[j] && rank_in[j] > rank_in[vic_w]) begin
				vic_w = WI_W'(j);
			end
		end
	end

	// Pick the way and its old rank
	always_comb begin
		if (any_hit) begin
			sel_w = hit_w;
			old_rank = {1'b0, rank_in[hit_w]};
		end else if (any_empty) begin
			sel_w = empty_w;
			old_rank = RANK_FILL;
		end else begin
			sel_w = vic_w;
			old_rank = {1'b0, rank_in[vic_w]};
		end
		outcome.hit = any_hit;
		outcome.miss = !any_hit;
		outcome.evict = !any_hit && !any_empty;
	end

	// Age younger ways, install the selected way
	always_comb begin
		valid_out = valid_in;
		tag_out = tag_in;
		rank_out = rank_in;
		for (int j = 0; j < WAYS; j++) begin
			if (WI_W'(j) == sel_w) begin
				valid_out[j] = 1'b1;
				tag_out[j] = tag;
				rank_out[j] = '0;
			end else if (use_mask[j] && valid_in[j] && ({1'b0, rank_in[j]} < old_rank)
					&& ({1'b0, rank_in[j]} < RANK_TOP)) begin
				rank_out[j] = rank_in[j] + 1'b1;
			end
		end
	end
endmodule

// ----- design/set_assoc_lru_cache_sim.sv -----
// Flow: an accepted word's set row is read in ST_READ, and the updated row and the result
// word are registered as the sequencer leaves ST_DONE. A new word is taken only in ST_IDLE,
// so each word passes read, write-back and the return to idle before the next is accepted;
// a fetch writes no row back. A modify updates the row in one pass. A held result word
// stalls write-back and the input. Reset: resets the sequencer, config registers and
// counters, then a clearing pass zeroes the set memory; no word is accepted until it ends.
// -----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache model with true LRU and saturating totals.
// -----------------------------------------------------------------------------
module set_assoc_lru_cache_sim
	import salc_pkg::*;
#(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8,
	parameter int ADDRESS_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	salc_req_if.sink    req,
	salc_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SET_W = $clog2(MAX_SETS);
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TAG_W = ADDRESS_BITS - 2;
	localparam int FLD_W = 1 + TAG_W + RANK_W;
	localparam int ROW_W = MAX_WAYS * FLD_W;
	localparam int WC_W = $clog2(MAX_WAYS + 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic [3:0] set_bits_q;
	logic [5:0] off_bits_q;
	logic [3:0] ways_q;
	logic [1:0] op_q;
	logic [TAG_W-1:0] tag_q;
	logic [SET_W-1:0] set_q;
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic rsp_valid_q;
	logic o_hit_q, o_miss_q, o_evict_q, o_hit2_q;

	// APB register port
	logic [1:0] reg_idx;
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	always_comb begin
		case (reg_idx)
			REG_SET_BITS: prdata = {28'd0, set_bits_q};
			REG_OFF_BITS: prdata = {26'd0, off_bits_q};
			REG_WAYS:     prdata = {28'd0, ways_q};
			default:      prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 4'd1;
			off_bits_q <= 6'd4;
			ways_q <= 4'd1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SET_BITS: set_bits_q <= pwdata[3:0];
				REG_OFF_BITS: off_bits_q <= pwdata[5:0];
				REG_WAYS:     ways_q <= pwdata[3:0];
				default:      ;
			endcase
		end
	end

	// Clamp config and split the address
	logic [4:0] s_eff;
	logic [5:0] b_eff;
	logic [WC_W-1:0] w_eff;
	logic [ADDRESS_BITS-1:0] a_sh;
	logic [15:0] idx16;
	logic [TAG_W-1:0] tag_d;
	logic [MAX_WAYS-1:0] use_mask;
	always_comb begin
		s_eff = (set_bits_q == 4'd0) ? 5'd1 : {1'b0, set_bits_q};
		b_eff = (off_bits_q == 6'd0) ? 6'd1 : ((off_bits_q > 6'd32) ? 6'd32 : off_bits_q);
		if (ways_q == 4'd0) begin
			w_eff = WC_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			w_eff = WC_W'(MAX_WAYS);
		end else begin
			w_eff = WC_W'(ways_q);
		end
		a_sh = req.address >> b_eff;
		idx16 = a_sh[15:0] & 16'((17'd1 << s_eff) - 17'd1);
		tag_d = TAG_W'(a_sh >> s_eff);
		for (int j = 0; j < MAX_WAYS; j++) begin
			use_mask[j] = (WC_W'(j) < w_eff);
		end
	end

	// Sequencer
	logic acc_take;
	logic done_go;
	logic is_fetch;
	assign req.ready = (state_q == ST_IDLE);
	assign acc_take = req.valid && req.ready;
	assign is_fetch = (op_q == OP_FETCH);
	// Leave write-back only once the result slot is free or being emptied
	assign done_go = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(MAX_SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc_take) state_q <= ST_READ;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: if (done_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_take) begin
			op_q <= req.operation;
			tag_q <= tag_d;
			set_q <= SET_W'(idx16);
		end
	end

	// Set memory: zeroed by the clearing pass, then written back per non-fetch access
	logic [ROW_W-1:0] rd_row, wr_row, mem_wdata;
	logic [SET_W-1:0] mem_waddr;
	logic mem_we;
	logic clearing;
	assign clearing = (state_q == ST_CLEAR);
	assign mem_we = clearing || (done_go && !is_fetch);
	assign mem_waddr = clearing ? clr_q : set_q;
	assign mem_wdata = clearing ? '0 : wr_row;
	salc_set_mem #(.SETS(MAX_SETS), .ROW_W(ROW_W)) u_mem (
		.clk(clk), .raddr(set_q), .rdata(rd_row),
		.we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata)
	);

	// Unpack row and apply the lookup; a modify's second access hits the
	// line just touched at rank zero and leaves the row unchanged
	logic [MAX_WAYS-1:0][TAG_W-1:0] tg_in, tg1;
	logic [MAX_WAYS-1:0][RANK_W-1:0] rk_in, rk1;
	logic [MAX_WAYS-1:0] vl_in, v1;
	outcome_t oc1;
	always_comb begin
		for (int j = 0; j < MAX_WAYS; j++) begin
			tg_in[j] = rd_row[j*FLD_W +: TAG_W];
			rk_in[j] = rd_row[j*FLD_W+TAG_W +: RANK_W];
			vl_in[j] = rd_row[j*FLD_W+TAG_W+RANK_W];
		end
	end

	salc_lookup #(.WAYS(MAX_WAYS), .TAG_W(TAG_W), .RANK_W(RANK_W)) u_lk1 (
		.valid_in(vl_in), .tag_in(tg_in), .rank_in(rk_in), .use_mask(use_mask),
		.tag(tag_q), .valid_out(v1), .tag_out(tg1), .rank_out(rk1), .outcome(oc1)
	);

	logic is_mod;
	assign is_mod = (op_q == OP_MODIFY);
	always_comb begin
		for (int j = 0; j < MAX_WAYS; j++) begin
			wr_row[j*FLD_W +: TAG_W] = tg1[j];
			wr_row[j*FLD_W+TAG_W +: RANK_W] = rk1[j];
			wr_row[j*FLD_W+TAG_W+RANK_W] = v1[j];
		end
	end

	// Counters and result word
	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W + 1)'(n);
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			evict_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			o_hit_q <= 1'b0;
			o_miss_q <= 1'b0;
			o_evict_q <= 1'b0;
			o_hit2_q <= 1'b0;
		end else if (done_go) begin
			rsp_valid_q <= 1'b1;
			o_hit_q <= oc1.hit && !is_fetch;
			o_miss_q <= oc1.miss && !is_fetch;
			o_evict_q <= oc1.evict && !is_fetch;
			o_hit2_q <= is_mod;
			if (!is_fetch) begin
				hit_cnt_q <= sat_add(hit_cnt_q, {1'b0, oc1.hit} + {1'b0, is_mod});
				miss_cnt_q <= sat_add(miss_cnt_q, {1'b0, oc1.miss});
				evict_cnt_q <= sat_add(evict_cnt_q, {1'b0, oc1.evict});
			end
		end else if (rsp_valid_q && rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = o_hit_q;
	assign rsp.miss = o_miss_q;
	assign rsp.evict = o_evict_q;
	assign rsp.second_hit = o_hit2_q;
	assign rsp.hit_total = hit_cnt_q;
	assign rsp.miss_total = miss_cnt_q;
	assign rsp.evict_total = evict_cnt_q;
endmodule

// ----- design/salc_checker.sv -----
// -----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache simulator's result channel.
// -----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_macros.svh"
module salc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        hit,
	input logic        miss,
	input logic        evict,
	input logic        second_hit,
	input logic [31:0] hit_total
);
	`SALC_ASSERT_IMP(a_hit_miss_excl, clk, arst_n, rsp_valid, !(hit && miss), "hit and miss")
	`SALC_ASSERT_IMP(a_evict_miss, clk, arst_n, rsp_valid && evict, miss, "evict no miss")
	`SALC_ASSERT_IMP(a_hit2_first, clk, arst_n, rsp_valid && second_hit, hit || miss,
		"second hit without access")
	`SALC_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(hit_total),
		"stalled word changed")
endmodule

bind set_assoc_lru_cache_sim salc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.hit(rsp.hit), .miss(rsp.miss), .evict(rsp.evict), .second_hit(rsp.second_hit),
	.hit_total(rsp.hit_total)
);
